// File: sv/msp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants of the sustain/pad note tracker.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int NOTE_COUNT = 128;
  localparam int NOTE_AW    = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int CNT_W      = $clog2(NOTE_COUNT + 1);

  localparam int MODE_W = 2;
  localparam int VEL_W  = 7;

  localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUST = 2'd2;

  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_POLY_AT  = 4'hA;
  localparam logic [3:0] TYPE_CTRL     = 4'hB;
  localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
  localparam logic [3:0] TYPE_CHAN_AT  = 4'hD;
  localparam logic [3:0] TYPE_PITCH    = 4'hE;

  localparam logic [6:0] CC_SUSTAIN    = 7'h40;
  localparam logic [6:0] PRESS_LEVEL   = 7'h40;
  localparam logic [6:0] VALUE_MAX     = 7'h7F;
  localparam logic [6:0] PAD_CTRL_RST  = 7'h42;
  localparam logic [3:0] PAD_OUT_RST   = 4'h1;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_IN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_IN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_CTRL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_OUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_OUT     = 3'd4;

  typedef struct packed {
    logic [3:0] primary_in_channel;
    logic [3:0] pad_in_channel;
    logic [6:0] pad_controller;
    logic [3:0] primary_out_channel;
    logic [3:0] pad_out_channel;
  } msp_cfg_t;

  typedef struct packed {
    logic       to_pad_port;
    logic [7:0] out_status;
    logic [6:0] out_data_one;
    logic [6:0] out_data_two;
  } msp_res_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_EMIT  = 5'b10000
  } msp_state_t;

  typedef enum logic {
    SK_RELEASE = 1'b0,
    SK_PAD     = 1'b1
  } msp_scan_t;

endpackage

// File: sv/msp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module msp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/msp_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_cfg_regs
// Configuration register file; writes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module msp_cfg_regs
  import msp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output msp_cfg_t             cfg
);

  msp_cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PRIMARY_IN:  cfg_nxt.primary_in_channel  = cfg_data[3:0];
        CFG_PAD_IN:      cfg_nxt.pad_in_channel      = cfg_data[3:0];
        CFG_PAD_CTRL:    cfg_nxt.pad_controller      = cfg_data;
        CFG_PRIMARY_OUT: cfg_nxt.primary_out_channel = cfg_data[3:0];
        CFG_PAD_OUT:     cfg_nxt.pad_out_channel     = cfg_data[3:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.primary_in_channel  <= 4'h0;
      cfg_r.pad_in_channel      <= 4'h0;
      cfg_r.pad_controller      <= PAD_CTRL_RST;
      cfg_r.primary_out_channel <= 4'h0;
      cfg_r.pad_out_channel     <= PAD_OUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: sv/msp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_out_reg
// Output holding register of the result channel.
// ----------------------------------------------------------------------------
module msp_out_reg
  import msp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  msp_res_t    res,
  output logic        slot_free,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [0:0]  out_tuser
);

  logic     vld_r, vld_nxt;
  msp_res_t res_r;

  assign slot_free  = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_tdata  = {2'b00, res_r.out_data_two, res_r.out_data_one, res_r.out_status};
  assign out_tuser  = res_r.to_pad_port;

  always_comb begin
    vld_nxt = vld_r;
    if (out_tready) begin
      vld_nxt = 1'b0;
    end
    if (load) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// File: sv/msp_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_engine
// Message decode, note table updates and table scans over the mode and
// velocity memories.
// ----------------------------------------------------------------------------
module msp_engine
  import msp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  msp_cfg_t           cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_from_primary_port,
  input  logic               in_from_pad_port,
  input  logic [7:0]         in_status_byte,
  input  logic [6:0]         in_data_one,
  input  logic [6:0]         in_data_two,
  // memory ports
  output logic               mode_we,
  output logic               vel_we,
  output logic [NOTE_AW-1:0] mem_waddr,
  output logic [MODE_W-1:0]  mode_wdata,
  output logic [VEL_W-1:0]   vel_wdata,
  output logic               mem_re,
  output logic [NOTE_AW-1:0] mem_raddr,
  input  logic [MODE_W-1:0]  mode_rdata,
  input  logic [VEL_W-1:0]   vel_rdata,
  // result path
  input  logic               slot_free,
  output logic               res_load,
  output msp_res_t           res
);

  msp_state_t state_r, state_nxt;
  msp_scan_t  kind_r, kind_nxt;

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               dv_r, dv_nxt;
  logic [NOTE_AW-1:0] da_r, da_nxt;
  logic               pedal_r, pedal_nxt;
  logic [6:0]         pad_note_r, pad_note_nxt;
  logic               res_vld_r, res_vld_nxt;
  msp_res_t           res_r, res_nxt;

  logic       it_prim_r, it_pad_r;
  logic [7:0] it_st_r;
  logic [6:0] it_d1_r, it_d2_r;

  logic       prim_hit, pad_hit, note_ok, issue, found;
  logic [7:0] p_note_off, p_note_on, p_ctrl, pd_note_on, pd_note_off;

  assign in_ready = (state_r == S_IDLE);
  assign res      = res_r;

  assign prim_hit = it_prim_r && (it_st_r[3:0] == cfg.primary_in_channel);
  assign pad_hit  = it_pad_r && (it_st_r == {TYPE_CTRL, cfg.pad_in_channel}) &&
                    (it_d1_r == cfg.pad_controller);
  assign note_ok  = 8'(it_d1_r) < 8'(NOTE_COUNT);

  assign p_note_off  = {TYPE_NOTE_OFF, cfg.primary_out_channel};
  assign p_note_on   = {TYPE_NOTE_ON, cfg.primary_out_channel};
  assign p_ctrl      = {TYPE_CTRL, cfg.primary_out_channel};
  assign pd_note_on  = {TYPE_NOTE_ON, cfg.pad_out_channel};
  assign pd_note_off = {TYPE_NOTE_OFF, cfg.pad_out_channel};

  assign issue = (cnt_r < CNT_W'(NOTE_COUNT)) && !found;
  assign found = dv_r && (kind_r == SK_PAD) && (mode_rdata != MODE_OFF);

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    cnt_nxt      = cnt_r;
    dv_nxt       = 1'b0;
    da_nxt       = da_r;
    pedal_nxt    = pedal_r;
    pad_note_nxt = pad_note_r;
    res_vld_nxt  = res_vld_r;
    res_nxt      = res_r;
    mode_we      = 1'b0;
    vel_we       = 1'b0;
    mem_waddr    = it_d1_r[NOTE_AW-1:0];
    mode_wdata   = MODE_OFF;
    vel_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = cnt_r[NOTE_AW-1:0];
    res_load     = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mode_we   = 1'b1;
        vel_we    = 1'b1;
        mem_waddr = cnt_r[NOTE_AW-1:0];
        if (cnt_r == CNT_W'(NOTE_COUNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_vld_nxt = 1'b0;
        state_nxt   = S_EMIT;
        cnt_nxt     = '0;
        res_nxt     = '{1'b0, it_st_r, it_d1_r, it_d2_r};
        if (prim_hit) begin
          case (it_st_r[7:4])
            TYPE_NOTE_OFF, TYPE_NOTE_ON: begin
              res_vld_nxt = 1'b1;
              if (it_st_r[7:4] == TYPE_NOTE_ON && it_d2_r != 7'd0) begin
                mode_we    = note_ok;
                vel_we     = note_ok;
                mode_wdata = MODE_ON;
                vel_wdata  = it_d2_r;
                res_nxt    = '{1'b0, p_note_on, it_d1_r, it_d2_r};
              end else begin
                mode_we    = note_ok;
                vel_we     = note_ok && !pedal_r;
                mode_wdata = pedal_r ? MODE_SUST : MODE_OFF;
                res_nxt    = '{1'b0, p_note_off, it_d1_r, 7'd0};
              end
            end
            TYPE_CTRL: begin
              res_vld_nxt = 1'b1;
              if (it_d1_r == CC_SUSTAIN) begin
                if (it_d2_r >= PRESS_LEVEL) begin
                  pedal_nxt = 1'b1;
                  res_nxt   = '{1'b0, p_ctrl, CC_SUSTAIN, VALUE_MAX};
                end else begin
                  pedal_nxt = 1'b0;
                  res_nxt   = '{1'b0, p_ctrl, CC_SUSTAIN, 7'd0};
                  kind_nxt  = SK_RELEASE;
                  state_nxt = S_SCAN;
                end
              end
            end
            TYPE_POLY_AT, TYPE_PROGRAM, TYPE_CHAN_AT, TYPE_PITCH: begin
              res_vld_nxt = 1'b1;
            end
            default: begin
              res_vld_nxt = 1'b0;
            end
          endcase
        end else if (pad_hit) begin
          if (it_d2_r >= PRESS_LEVEL) begin
            kind_nxt  = SK_PAD;
            state_nxt = S_SCAN;
          end else begin
            res_vld_nxt = 1'b1;
            res_nxt     = '{1'b1, pd_note_off, pad_note_r, 7'd0};
          end
        end
      end

      S_SCAN: begin
        mem_re = issue;
        dv_nxt = issue;
        da_nxt = cnt_r[NOTE_AW-1:0];
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        // sustained entries drop to off as they stream past
        if (dv_r && kind_r == SK_RELEASE && mode_rdata == MODE_SUST) begin
          mode_we   = 1'b1;
          vel_we    = 1'b1;
          mem_waddr = da_r;
        end
        if (found) begin
          res_vld_nxt  = 1'b1;
          res_nxt      = '{1'b1, pd_note_on, 7'(da_r), vel_rdata};
          pad_note_nxt = 7'(da_r);
          dv_nxt       = 1'b0;
          state_nxt    = S_EMIT;
        end else if (!dv_r && cnt_r == CNT_W'(NOTE_COUNT)) begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!res_vld_r) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      kind_r     <= SK_RELEASE;
      cnt_r      <= '0;
      dv_r       <= 1'b0;
      pedal_r    <= 1'b0;
      pad_note_r <= 7'd0;
      res_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      kind_r     <= kind_nxt;
      cnt_r      <= cnt_nxt;
      dv_r       <= dv_nxt;
      pedal_r    <= pedal_nxt;
      pad_note_r <= pad_note_nxt;
      res_vld_r  <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    da_r  <= da_nxt;
    res_r <= res_nxt;
    if (in_valid && in_ready) begin
      it_prim_r <= in_from_primary_port;
      it_pad_r  <= in_from_pad_port;
      it_st_r   <= in_status_byte;
      it_d1_r   <= in_data_one;
      it_d2_r   <= in_data_two;
    end
  end

endmodule

// File: sv/midi_sustain_pad_note_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_sustain_pad_note_tracker
// Sustain pedal and pad note tracker for three-byte MIDI channel messages.
// ----------------------------------------------------------------------------
// Input items arrive on the in_ stream: tdata holds status, data one and
// data two; tuser holds the source port flags. Each item gives zero or one
// result on the out_ stream: tdata holds status, data one and data two of
// the emitted message, tuser selects the pad output.
// Configuration is written through cfg_valid/cfg_index/cfg_data; the user
// must write it only while idle, which the block itself does not enforce.
// Note mode and velocity live in two one-read/one-write memories.
// An item is taken in S_IDLE and decoded in S_EXEC in the cycle after; in
// S_EMIT the result is loaded into the output register once the slot is free.
// A sustain release or pad press walks the note memory one entry per cycle.
// After reset a clearing pass zeroes every entry of the memories;
// in_tready stays low during it while configuration writes are taken.
// A stalled receiver holds the result in the output register; the block
// takes and decodes the next item meanwhile and waits only when it has a
// second result to deliver.
// ----------------------------------------------------------------------------
module midi_sustain_pad_note_tracker
  import msp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // status_byte, data_one, data_two
  input  logic [1:0]           in_tuser,   // from_primary_port, from_pad_port
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // out_status, out_data_one, out_data_two
  output logic [0:0]           out_tuser,  // to_pad_port
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  msp_cfg_t           cfg;
  msp_res_t           res;
  logic               res_load, slot_free;
  logic               mode_we, vel_we, mem_re;
  logic [NOTE_AW-1:0] mem_waddr, mem_raddr;
  logic [MODE_W-1:0]  mode_wdata, mode_rdata;
  logic [VEL_W-1:0]   vel_wdata, vel_rdata;

  msp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  msp_ram #(.WIDTH(MODE_W), .DEPTH(NOTE_COUNT)) u_mode_ram (
    .clk     (clk),
    .wr_en   (mode_we),
    .wr_addr (mem_waddr),
    .wr_data (mode_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mode_rdata)
  );

  msp_ram #(.WIDTH(VEL_W), .DEPTH(NOTE_COUNT)) u_vel_ram (
    .clk     (clk),
    .wr_en   (vel_we),
    .wr_addr (mem_waddr),
    .wr_data (vel_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (vel_rdata)
  );

  msp_engine u_engine (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .in_valid             (in_tvalid),
    .in_ready             (in_tready),
    .in_from_primary_port (in_tuser[0]),
    .in_from_pad_port     (in_tuser[1]),
    .in_status_byte       (in_tdata[7:0]),
    .in_data_one          (in_tdata[14:8]),
    .in_data_two          (in_tdata[21:15]),
    .mode_we              (mode_we),
    .vel_we               (vel_we),
    .mem_waddr            (mem_waddr),
    .mode_wdata           (mode_wdata),
    .vel_wdata            (vel_wdata),
    .mem_re               (mem_re),
    .mem_raddr            (mem_raddr),
    .mode_rdata           (mode_rdata),
    .vel_rdata            (vel_rdata),
    .slot_free            (slot_free),
    .res_load             (res_load),
    .res                  (res)
  );

  msp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_load),
    .res        (res),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: bench/midi_sustain_pad_note_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_sustain_pad_note_tracker_tb
// Self-checking bench for the sustain/pad note tracker.
// ----------------------------------------------------------------------------
// Keeps its own copy of the note table, pedal flag, pad note and registers,
// and predicts the MIDI message each accepted item gives. Emitted messages are
// compared in order against the predicted ones. A directed run at reset
// settings comes first. Random traffic follows under several register
// settings, then an unthrottled stretch and a long output stall.
// ----------------------------------------------------------------------------
module midi_sustain_pad_note_tracker_tb;
  import msp_pkg::*;

  localparam int DRAIN_CYCLES   = NOTE_COUNT + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int STALL_CYCLES   = 300;

  typedef struct packed {
    logic       from_primary;
    logic       from_pad;
    logic [7:0] status;
    logic [6:0] data_one;
    logic [6:0] data_two;
  } in_item_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata   = '0;  // status_byte, data_one, data_two
  logic [1:0]           in_tuser   = '0;  // from_primary_port, from_pad_port
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;        // out_status, out_data_one, out_data_two
  logic [0:0]           out_tuser;        // to_pad_port
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DAT_W-1:0] cfg_data   = '0;

  // tracker state
  msp_cfg_t          reg_shadow;
  logic [MODE_W-1:0] note_modes [NOTE_COUNT];
  logic [VEL_W-1:0]  note_vels  [NOTE_COUNT];
  logic              pedal_down;
  logic [6:0]        pad_key;

  msp_res_t    due_messages [$];
  int unsigned bad_messages = 0;
  int unsigned stall_count  = 0;
  bit          tx_idle_on   = 1'b1;
  bit          rx_idle_on   = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  midi_sustain_pad_note_tracker i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic in_item_t make_item(input logic fp, input logic fpad,
                                         input logic [7:0] st, input logic [6:0] d1,
                                         input logic [6:0] d2);
    in_item_t m;
    m = {fp, fpad, st, d1, d2};
    return m;
  endfunction

  function automatic void release_note(input logic [6:0] note);
    if (pedal_down) begin
      note_modes[note] = MODE_SUST;
    end else begin
      note_modes[note] = MODE_OFF;
      note_vels[note]  = '0;
    end
  endfunction

  // Returns 1 when the message produces an output message.
  function automatic bit track_message(input in_item_t m, output msp_res_t r);
    logic [3:0] pout;
    logic [3:0] padout;
    int         n;
    pout   = reg_shadow.primary_out_channel;
    padout = reg_shadow.pad_out_channel;
    r      = '0;
    if (m.from_primary && m.status[3:0] == reg_shadow.primary_in_channel) begin
      case (m.status[7:4])
        TYPE_NOTE_OFF, TYPE_NOTE_ON: begin
          if (m.status[7:4] == TYPE_NOTE_ON && m.data_two != '0) begin
            note_modes[m.data_one] = MODE_ON;
            note_vels[m.data_one]  = m.data_two;
            r = {1'b0, TYPE_NOTE_ON, pout, m.data_one, m.data_two};
          end else begin
            release_note(m.data_one);
            r = {1'b0, TYPE_NOTE_OFF, pout, m.data_one, 7'd0};
          end
          return 1'b1;
        end
        TYPE_CTRL: begin
          if (m.data_one != CC_SUSTAIN) begin
            r = {1'b0, m.status, m.data_one, m.data_two};
          end else if (m.data_two >= PRESS_LEVEL) begin
            pedal_down = 1'b1;
            r = {1'b0, TYPE_CTRL, pout, CC_SUSTAIN, VALUE_MAX};
          end else begin
            for (n = 0; n < NOTE_COUNT; n++) begin
              if (note_modes[n] == MODE_SUST) begin
                note_modes[n] = MODE_OFF;
                note_vels[n]  = '0;
              end
            end
            pedal_down = 1'b0;
            r = {1'b0, TYPE_CTRL, pout, CC_SUSTAIN, 7'd0};
          end
          return 1'b1;
        end
        TYPE_POLY_AT, TYPE_PROGRAM, TYPE_CHAN_AT, TYPE_PITCH: begin
          r = {1'b0, m.status, m.data_one, m.data_two};
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    end
    if (m.from_pad && m.status == {TYPE_CTRL, reg_shadow.pad_in_channel} &&
        m.data_one == reg_shadow.pad_controller) begin
      if (m.data_two >= PRESS_LEVEL) begin
        for (n = 0; n < NOTE_COUNT; n++) begin
          if (note_modes[n] != MODE_OFF) begin
            pad_key = 7'(n);
            r = {1'b1, TYPE_NOTE_ON, padout, 7'(n), note_vels[n]};
            return 1'b1;
          end
        end
        return 1'b0;
      end
      r = {1'b1, TYPE_NOTE_OFF, padout, pad_key, 7'd0};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [6:0] pick_note();
    if ($urandom_range(3) == 0) return 7'($urandom_range(127));
    return 7'(40 + $urandom_range(15));
  endfunction

  function automatic in_item_t compose_message();
    in_item_t   m;
    int         pick;
    logic [3:0] kind;
    pick           = $urandom_range(99);
    m.from_primary = 1'b1;
    m.from_pad     = 1'($urandom_range(1));
    m.data_one     = 7'($urandom_range(127));
    m.data_two     = 7'($urandom_range(127));
    if (pick < 30) begin
      m.status   = {TYPE_NOTE_ON, reg_shadow.primary_in_channel};
      m.data_one = pick_note();
      if ($urandom_range(9) == 0) m.data_two = '0;
    end else if (pick < 45) begin
      m.status   = {TYPE_NOTE_OFF, reg_shadow.primary_in_channel};
      m.data_one = pick_note();
    end else if (pick < 55) begin
      m.status   = {TYPE_CTRL, reg_shadow.primary_in_channel};
      m.data_one = CC_SUSTAIN;
    end else if (pick < 70) begin
      m.from_primary = 1'($urandom_range(1));
      m.from_pad     = 1'b1;
      m.status       = {TYPE_CTRL, reg_shadow.pad_in_channel};
      m.data_one     = reg_shadow.pad_controller;
    end else if (pick < 80) begin
      case ($urandom_range(4))
        0:       kind = TYPE_POLY_AT;
        1:       kind = TYPE_PROGRAM;
        2:       kind = TYPE_CHAN_AT;
        3:       kind = TYPE_PITCH;
        default: kind = TYPE_CTRL;
      endcase
      m.status = {kind, reg_shadow.primary_in_channel};
    end else begin
      m = in_item_t'(24'($urandom));
    end
    return m;
  endfunction

  function automatic void log_mismatch(input string why, input msp_res_t want,
                                       input msp_res_t got);
    bad_messages++;
    if (bad_messages <= 10)
      $display("%s: expected port %0d status %h data %h %h, got port %0d status %h data %h %h",
               why, want.to_pad_port, want.out_status, want.out_data_one,
               want.out_data_two, got.to_pad_port, got.out_status, got.out_data_one,
               got.out_data_two);
  endfunction

  task automatic send_item(input in_item_t m);
    msp_res_t r;
    if (tx_idle_on && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, m.data_two, m.data_one, m.status};
    in_tuser  <= {m.from_pad, m.from_primary};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    if (track_message(m, r)) due_messages.push_back(r);
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (due_messages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    case (idx)
      CFG_PRIMARY_IN:  reg_shadow.primary_in_channel  = val[3:0];
      CFG_PAD_IN:      reg_shadow.pad_in_channel      = val[3:0];
      CFG_PAD_CTRL:    reg_shadow.pad_controller      = val;
      CFG_PRIMARY_OUT: reg_shadow.primary_out_channel = val[3:0];
      CFG_PAD_OUT:     reg_shadow.pad_out_channel     = val[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DAT_W-1:0] pin, input logic [CFG_DAT_W-1:0] padin,
                              input logic [CFG_DAT_W-1:0] ctrl, input logic [CFG_DAT_W-1:0] pout,
                              input logic [CFG_DAT_W-1:0] padout);
    drain();
    write_reg(CFG_PRIMARY_IN, pin);
    write_reg(CFG_PAD_IN, padin);
    // unmapped index, must be ignored
    write_reg(CFG_IDX_W'(CFG_PAD_OUT + 1 + $urandom_range(2)), 7'($urandom_range(127)));
    write_reg(CFG_PAD_CTRL, ctrl);
    write_reg(CFG_PRIMARY_OUT, pout);
    write_reg(CFG_PAD_OUT, padout);
    cfg_valid <= 1'b0;
  endtask

  task automatic play_random(input int count);
    repeat (count) send_item(compose_message());
  endtask

  task automatic test_reset_behavior();
    logic [7:0] pad_cc;
    logic [7:0] prim_cc;
    pad_cc  = {TYPE_CTRL, 4'd0};
    prim_cc = {TYPE_CTRL, 4'd0};
    send_item(make_item(1'b0, 1'b1, pad_cc, PAD_CTRL_RST, PRESS_LEVEL));     // nothing active
    send_item(make_item(1'b0, 1'b1, pad_cc, PAD_CTRL_RST, PRESS_LEVEL - 7'd1)); // no press
    send_item(make_item(1'b1, 1'b0, {TYPE_NOTE_ON, 4'd0}, 7'd0, VALUE_MAX));
    send_item(make_item(1'b1, 1'b1, {TYPE_NOTE_ON, 4'd0}, VALUE_MAX, 7'd1));
    send_item(make_item(1'b1, 1'b0, {TYPE_NOTE_ON, 4'd0}, VALUE_MAX, 7'd0)); // zero velocity
    send_item(make_item(1'b0, 1'b1, pad_cc, PAD_CTRL_RST, VALUE_MAX));
    send_item(make_item(1'b1, 1'b0, prim_cc, CC_SUSTAIN, PRESS_LEVEL));
    send_item(make_item(1'b1, 1'b0, {TYPE_NOTE_OFF, 4'd0}, 7'd0, VALUE_MAX));
    send_item(make_item(1'b0, 1'b1, pad_cc, PAD_CTRL_RST, PRESS_LEVEL));     // sustained note
    send_item(make_item(1'b1, 1'b0, prim_cc, CC_SUSTAIN, PRESS_LEVEL - 7'd1));
    send_item(make_item(1'b0, 1'b1, pad_cc, PAD_CTRL_RST, VALUE_MAX));       // table empty again
    send_item(make_item(1'b0, 1'b1, pad_cc, PAD_CTRL_RST, 7'd0));
    send_item(make_item(1'b1, 1'b0, {TYPE_POLY_AT, 4'd0}, VALUE_MAX, VALUE_MAX));
    send_item(make_item(1'b1, 1'b0, {TYPE_PROGRAM, 4'd0}, 7'h12, 7'h34));
    send_item(make_item(1'b1, 1'b0, {TYPE_CHAN_AT, 4'd0}, 7'd0, VALUE_MAX));
    send_item(make_item(1'b1, 1'b0, {TYPE_PITCH, 4'd0}, VALUE_MAX, 7'd0));
    send_item(make_item(1'b1, 1'b1, prim_cc, PAD_CTRL_RST, VALUE_MAX));      // primary wins
    send_item(make_item(1'b1, 1'b0, 8'h00, 7'd0, 7'd0));
    send_item(make_item(1'b1, 1'b1, 8'h7F, VALUE_MAX, VALUE_MAX));
    send_item(make_item(1'b1, 1'b0, 8'hF0, 7'h55, 7'h2A));
    send_item(make_item(1'b1, 1'b1, 8'hFF, VALUE_MAX, VALUE_MAX));
    send_item(make_item(1'b1, 1'b1, {TYPE_NOTE_ON, 4'd3}, 7'h10, 7'h10));  // wrong channel
    send_item(make_item(1'b0, 1'b0, {TYPE_NOTE_ON, 4'd0}, 7'h10, 7'h10));  // no port
    send_item(make_item(1'b0, 1'b1, pad_cc, PAD_CTRL_RST - 7'd1, VALUE_MAX));
    send_item(make_item(1'b0, 1'b1, {TYPE_CTRL, 4'd1}, PAD_CTRL_RST, VALUE_MAX));
  endtask

  task automatic test_register_settings();
    logic [CFG_DAT_W-1:0] shared;
    program_regs(7'h0F, 7'h0F, 7'h7F, 7'h0F, 7'h00);
    play_random(200);
    program_regs(7'h00, 7'h00, 7'h00, 7'h00, 7'h0F);
    play_random(200);
    shared = 7'($urandom_range(127));
    program_regs(shared, shared, 7'($urandom_range(127)), 7'($urandom_range(127)),
                 7'($urandom_range(127)));
    play_random(200);
    repeat (3) begin
      program_regs(7'($urandom_range(127)), 7'($urandom_range(127)), 7'($urandom_range(127)),
                   7'($urandom_range(127)), 7'($urandom_range(127)));
      play_random(200);
    end
  endtask

  task automatic test_steady_stream();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    play_random(150);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_output_stall();
    tx_idle_on = 1'b0;
    hold_requests++;
    play_random(60);
    tx_idle_on = 1'b1;
  endtask

  // receiver readiness, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = STALL_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (rx_idle_on) begin
      out_tready <= ($urandom_range(99) >= 16);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(negedge clk) begin : check_result
    msp_res_t got;
    msp_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tdata[7:0], out_tdata[14:8], out_tdata[21:15]};
      if (due_messages.size() == 0) begin
        log_mismatch("unexpected message", '0, got);
      end else begin
        want = due_messages.pop_front();
        if (got !== want) log_mismatch("mismatch", want, got);
      end
    end
  end

  always @(negedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_count = 0;
    end else if (rst_n) begin
      stall_count++;
      if (stall_count >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    reg_shadow = '{primary_in_channel: 4'd0, pad_in_channel: 4'd0,
                   pad_controller: PAD_CTRL_RST, primary_out_channel: 4'd0,
                   pad_out_channel: PAD_OUT_RST};
    for (int n = 0; n < NOTE_COUNT; n++) begin
      note_modes[n] = MODE_OFF;
      note_vels[n]  = '0;
    end
    pedal_down = 1'b0;
    pad_key    = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_behavior();
    test_register_settings();
    test_steady_stream();
    test_output_stall();
    drain();
    if (due_messages.size() != 0) begin
      bad_messages += due_messages.size();
      $display("%0d messages never emitted", due_messages.size());
    end
    if (bad_messages == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
